// ===== rtl/bin1331_pkg.sv =====
// Shared types, constants and the 1-3-3-1 tap function for the binomial downsampler.
package bin1331_pkg;

   localparam int PIX_W = 8;
   localparam int CFG_W = 12;
   localparam int ROW_W = 12;

   // Register word index (address bit 2)
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Horizontal stage result handed to the vertical stage
   typedef struct packed {
      logic             have;       // a horizontal value is produced this beat
      logic             emit;       // a result pixel follows from it
      logic             odd_row;    // row is odd (bottom edge case when a result follows)
      logic             first_row;  // top edge: replicate
      logic             row_end;
      logic             frame_end;
      logic [1:0]       slot;       // line slot of the current row (row mod 3)
      logic [PIX_W-1:0] hval;
   } hcmd_type;

   function automatic logic [PIX_W-1:0] tap4(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] d);
      logic [PIX_W+2:0] sum;
      sum = {3'd0, a} + {2'd0, b, 1'b0} + {3'd0, b}
          + {2'd0, c, 1'b0} + {3'd0, c} + {3'd0, d};
      return sum[PIX_W+2:3];
   endfunction

   // Slot of the row before (row - 1 mod 3)
   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   // Slot of the row two before (row + 1 mod 3)
   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

endpackage

// ===== rtl/bin1331_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port (read-first).
module bin1331_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bin1331_hfilt.sv =====
// Horizontal 1-3-3-1 stage: pixel history, column/row counters, line slot select.
module bin1331_hfilt #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic [bin1331_pkg::PIX_W-1:0]       pixel_in,
   input  logic [bin1331_pkg::CFG_W-1:0]       width_cfg,
   input  logic [bin1331_pkg::CFG_W-1:0]       height_cfg,
   output bin1331_pkg::hcmd_type               cmd,
   output logic [$clog2(MAX_WIDTH/2)-1:0]      col_idx
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int AW = $clog2(MAX_WIDTH / 2);
   localparam logic [CW-1:0] WM1_MAX  = CW'(MAX_WIDTH - 1);
   localparam logic [CW-2:0] HALF_ONE = (CW-1)'(1);

   logic [CW-1:0]                         col_ff, col_in;
   logic [bin1331_pkg::ROW_W-1:0]         row_ff, row_in;
   logic [1:0]                            slot_ff, slot_in;
   logic [2:0][bin1331_pkg::PIX_W-1:0]    pix_ff, pix_in;

   logic [CW-1:0]                         wm1;
   logic [bin1331_pkg::ROW_W-1:0]         hm1;
   logic                                  last_col, last_row;
   logic [CW-2:0]                         half, j_wide;
   logic                                  even_tap, edge_tap, even_row, odd_last;
   logic [bin1331_pkg::PIX_W-1:0]         tap_a, hv;

   always_comb begin
      // saturate frame size
      if (32'(width_cfg) > 32'(MAX_WIDTH)) begin
         wm1 = WM1_MAX;
      end else if (width_cfg < 12'd2) begin
         wm1 = CW'(1);
      end else begin
         wm1 = CW'(width_cfg - 12'd1);
      end
      hm1 = (height_cfg < 12'd2) ? 12'd1 : height_cfg - 12'd1;

      last_col = col_ff >= wm1;
      last_row = row_ff >= hm1;

      half     = col_ff[CW-1:1];
      even_tap = !col_ff[0] && (half != '0);
      edge_tap = col_ff[0] && last_col;

      if (even_tap) begin
         j_wide = half - HALF_ONE;
         tap_a  = (half == HALF_ONE) ? pix_ff[1] : pix_ff[2];
         hv     = bin1331_pkg::tap4(tap_a, pix_ff[1], pix_ff[0], pixel_in);
      end else begin
         // right edge on even width: replicate last pixel
         j_wide = half;
         tap_a  = (half == '0) ? pix_ff[0] : pix_ff[1];
         hv     = bin1331_pkg::tap4(tap_a, pix_ff[0], pixel_in, pixel_in);
      end

      even_row = !row_ff[0] && (row_ff[bin1331_pkg::ROW_W-1:1] != '0);
      odd_last = row_ff[0] && last_row;

      cmd.have      = even_tap || edge_tap;
      cmd.emit      = (even_tap || edge_tap) && (even_row || odd_last);
      cmd.odd_row   = row_ff[0];
      cmd.first_row = (row_ff == 12'd2) || (row_ff == 12'd1);
      cmd.row_end   = last_col;
      cmd.frame_end = last_col && last_row;
      cmd.slot      = slot_ff;
      cmd.hval      = hv;
      col_idx       = j_wide[AW-1:0];

      // next state
      pix_in = {pix_ff[1], pix_ff[0], pixel_in};
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in  = '0;
            slot_in = 2'd0;
         end else begin
            row_in  = row_ff + 12'd1;
            slot_in = bin1331_pkg::slot_next(slot_ff);
         end
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= 2'd0;
      end else if (fire) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pix_ff <= pix_in;
      end
   end

endmodule

// ===== rtl/bin1331_vfilt.sv =====
// Vertical 1-3-3-1 stage and output register with stall control.
module bin1331_vfilt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  bin1331_pkg::hcmd_type                cmd_in,
   input  logic [2:0][bin1331_pkg::PIX_W-1:0]   line_data,
   output logic                                 take_ok,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [bin1331_pkg::PIX_W-1:0]        rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);

   logic                                 s1_valid_ff, s1_valid_in;
   bin1331_pkg::hcmd_type                s1_cmd_ff;
   logic                                 out_valid_ff, out_valid_in;
   logic [bin1331_pkg::PIX_W-1:0]        out_pix_ff, out_pix_in;
   logic                                 out_last_ff, out_user_ff;

   logic                                 advance;
   logic [bin1331_pkg::PIX_W-1:0]        row0, row1, row2;   // rows r-3, r-1, r-2
   logic [bin1331_pkg::PIX_W-1:0]        ta, tb, tc, td;

   always_comb begin
      advance = !out_valid_ff || rsp_tready;
      take_ok = !s1_valid_ff || advance;

      row0 = line_data[s1_cmd_ff.slot];
      row1 = line_data[bin1331_pkg::slot_prev(s1_cmd_ff.slot)];
      row2 = line_data[bin1331_pkg::slot_next(s1_cmd_ff.slot)];

      if (s1_cmd_ff.odd_row) begin
         // bottom edge: current row replicated
         tb = row1;
         ta = s1_cmd_ff.first_row ? row1 : row2;
         tc = s1_cmd_ff.hval;
         td = s1_cmd_ff.hval;
      end else begin
         tb = row2;
         ta = s1_cmd_ff.first_row ? row2 : row0;
         tc = row1;
         td = s1_cmd_ff.hval;
      end
      out_pix_in = bin1331_pkg::tap4(ta, tb, tc, td);

      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_cmd_ff <= cmd_in;
      end
      if (advance && s1_valid_ff) begin
         out_pix_ff  <= out_pix_in;
         out_last_ff <= s1_cmd_ff.row_end;
         out_user_ff <= s1_cmd_ff.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== rtl/binomial_1331_downsample_2x.sv =====
// Separable 1-3-3-1 binomial filter with 2x decimation in both directions, 8-bit grey.
//
// Pixels stream in raster order, one beat per pixel, frame after frame; the output is
// the floor(W/2) x floor(H/2) image with edges replicated. One pixel is taken every
// clock while the result side keeps up. A result beat passes the registered read of
// the line store, held with its command, and then the output register. Only every
// other pixel of every other row makes a result, plus the right column on even
// widths and the bottom row on even heights. The line store is three RAMs of
// MAX_WIDTH/2 entries, one per filtered row slot (row mod 3); it is not cleared by
// reset, but the counters are. Size registers are saturated to 2..MAX_WIDTH and
// 2..4095 and should be written between frames.
module binomial_1331_downsample_2x #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // input pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // [7:0] pixel_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,      // [7:0] pixel_out
   output logic        rsp_tlast,      // row_end
   output logic        rsp_tuser,      // [0] frame_end
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SEG_LEN = MAX_WIDTH / 2;
   localparam int AW      = $clog2(SEG_LEN);

   logic [bin1331_pkg::CFG_W-1:0]        cfg_width_ff, cfg_height_ff;
   logic                                 csr_wr;
   logic                                 req_fire;
   bin1331_pkg::hcmd_type                hcmd;
   logic [AW-1:0]                        col_idx;
   logic [2:0][bin1331_pkg::PIX_W-1:0]   line_data;
   logic                                 take_ok;

   // ---- configuration registers ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 12'd2048;
         cfg_height_ff <= 12'd2048;
      end else if (csr_wr) begin
         if (csr_paddr[2] == bin1331_pkg::REG_HEIGHT) begin
            cfg_height_ff <= csr_pwdata[bin1331_pkg::CFG_W-1:0];
         end else begin
            cfg_width_ff  <= csr_pwdata[bin1331_pkg::CFG_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == bin1331_pkg::REG_HEIGHT) ?
                       {20'd0, cfg_height_ff} : {20'd0, cfg_width_ff};

   // ---- input handshake ----
   assign req_tready = take_ok;
   assign req_fire   = req_tvalid && req_tready;

   // ---- horizontal stage ----
   bin1331_hfilt #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_hfilt (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .pixel_in   (req_tdata),
      .width_cfg  (cfg_width_ff),
      .height_cfg (cfg_height_ff),
      .cmd        (hcmd),
      .col_idx    (col_idx)
   );

   // ---- line store: one RAM per row slot; the current slot reads old data then writes ----
   for (genvar k = 0; k < 3; k++) begin : g_line
      bin1331_ram #(
         .WIDTH (bin1331_pkg::PIX_W),
         .DEPTH (SEG_LEN)
      ) u_ram (
         .clock   (clock),
         .wr_en   (req_fire && hcmd.have && (hcmd.slot == 2'(k))),
         .wr_addr (col_idx),
         .wr_data (hcmd.hval),
         .rd_en   (req_fire),
         .rd_addr (col_idx),
         .rd_data (line_data[k])
      );
   end

   // ---- vertical stage and output register ----
   bin1331_vfilt u_vfilt (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire && hcmd.emit),
      .cmd_in     (hcmd),
      .line_data  (line_data),
      .take_ok    (take_ok),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // frame end is always also a row end
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   // input stalls only behind a blocked output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while output free");

   // a result only comes from a freshly filtered horizontal value
   a_emit_have: assert property (@(posedge clock) disable iff (reset)
      req_fire && hcmd.emit |-> hcmd.have)
      else $error("result without horizontal value");

   // a result beat follows after the command stage and the output register when the output is free
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire && hcmd.emit && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result not delivered");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the 2x binomial downsampler: scored pixel stream under random flow control.
module tb_top;

   // Must match the line store depth built into the block
   localparam int MAX_W         = 2048;
   localparam int LINE_SLOTS    = MAX_W / 2;
   // Input beat to result beat: line store read, then output register
   localparam int BLOCK_LATENCY = 2;
   // Generous ceiling on the length of the whole run
   localparam int CYCLE_LIMIT   = 1_000_000;

   // One downsampled pixel as it leaves the block
   typedef struct packed {
      logic [7:0] pix;
      logic       row_end;
      logic       frame_end;
   } down_pixel_type;

   // Fill used for the pixels of one frame
   typedef enum {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_ALTERNATE} fill_kind_type;

   // ---------------------------------------------------------------- DUT signals
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;     // [7:0] pixel_in
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] pixel_out
   logic        rsp_tlast;            // row_end
   logic        rsp_tuser;            // [0] frame_end
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // ---------------------------------------------------------------- bench state
   // Predictor copy of the block: size registers, filtered rows, pixel history,
   // position in the frame.
   logic [11:0] cfg_width  = 12'd2048;
   logic [11:0] cfg_height = 12'd2048;
   logic [7:0]  hrow_store [3][LINE_SLOTS] = '{default: '0};
   logic [7:0]  px_hist [3] = '{default: '0};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   down_pixel_type expected_pixels [$];  // predicted results, oldest first
   int unsigned mismatch_count = 0;
   int unsigned pixels_sent    = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;   // chance of a gap after each input beat
   int unsigned rsp_stall_pct  = 0;   // chance rsp_tready is low in a cycle
   logic        rsp_hold       = 1'b0; // long receiver hold-off in progress

   binomial_1331_downsample_2x #(.MAX_WIDTH(MAX_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   // Sizes as the block uses them: saturated to 2..MAX_W and 2..4095
   function automatic int unsigned frame_cols();
      int unsigned w;
      w = cfg_width;
      if (w < 2) w = 2;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned frame_rows();
      int unsigned h;
      h = cfg_height;
      if (h < 2) h = 2;
      return h;
   endfunction

   // (a + 3b + 3c + d) >> 3, at most 2040 before the shift
   function automatic logic [7:0] tap_1331(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
      logic [10:0] acc;
      acc = 11'(a) + 11'(b) * 11'd3 + 11'(c) * 11'd3 + 11'(d);
      return acc[10:3];
   endfunction

   // Advance the predictor by one accepted input pixel; queue a result if one is due.
   function automatic void downsample_step(input logic [7:0] cur);
      int unsigned w, h, c, r, j, s_cur, s_prev, s_prev2;
      logic        last_col, last_row, have_h, emit;
      logic [7:0]  hv, t, v;
      down_pixel_type res;
      w = frame_cols();
      h = frame_rows();
      c = col_pos;
      r = row_pos;
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      have_h = 1'b0;
      emit = 1'b0;
      j = 0;
      hv = '0;
      v = '0;

      // Horizontal tap: complete on every even column past 0, and on an odd
      // last column where the right edge is replicated.
      if (c >= 2 && c % 2 == 0) begin
         j = (c - 2) / 2;
         t = (j != 0) ? px_hist[2] : px_hist[1];   // left edge replicated
         hv = tap_1331(t, px_hist[1], px_hist[0], cur);
         have_h = 1'b1;
      end else if (last_col && c % 2 == 1) begin
         j = (c - 1) / 2;
         t = (j != 0) ? px_hist[1] : px_hist[0];
         hv = tap_1331(t, px_hist[0], cur, cur);
         have_h = 1'b1;
      end
      px_hist[2] = px_hist[1];
      px_hist[1] = px_hist[0];
      px_hist[0] = cur;

      // Vertical tap over rows r-3..r, slots rotate with row mod 3
      if (have_h && j < LINE_SLOTS) begin
         s_cur   = r % 3;
         s_prev  = (r + 2) % 3;
         s_prev2 = (r + 1) % 3;
         if (r >= 2 && r % 2 == 0) begin
            t = (r == 2) ? hrow_store[s_prev2][j] : hrow_store[s_cur][j];  // top edge
            v = tap_1331(t, hrow_store[s_prev2][j], hrow_store[s_prev][j], hv);
            emit = 1'b1;
         end else if (last_row && r % 2 == 1) begin
            // Bottom edge replicated on the final odd row
            t = (r == 1) ? hrow_store[s_prev][j] : hrow_store[s_prev2][j];
            v = tap_1331(t, hrow_store[s_prev][j], hv, hv);
            emit = 1'b1;
         end
         if (emit) begin
            res.pix       = v;
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            expected_pixels.push_back(res);
         end
         hrow_store[s_cur][j] = hv;
      end

      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // ---------------------------------------------------------------- result side
   // Score every result beat, then pick rsp_tready for the next cycle.
   always @(posedge clock) begin : result_check
      down_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result beat, got pixel %0d row_end %0b frame_end %0b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata !== want.pix) begin
               $display("%0t: pixel_out expected %0d, got %0d", $time, want.pix, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.row_end) begin
               $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser !== want.frame_end) begin
               $display("%0t: frame_end expected %0b, got %0b",
                        $time, want.frame_end, rsp_tuser);
               mismatch_count++;
            end
         end
      end
      if (rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Receiver holds off in a process of its own, for as long as n says
   task automatic hold_results(input int unsigned n);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
   endtask

   // ---------------------------------------------------------------- input side
   // One pixel beat. valid stays up into the next beat unless a gap is taken,
   // so back-to-back beats never see valid dropped and raised in one step.
   task automatic send_pixel(input logic [7:0] px, input logic frame_done);
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      downsample_step(px);
      if (frame_done || $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic send_frame(input fill_kind_type fill);
      int unsigned n_pix;
      logic [7:0]  px;
      n_pix = frame_cols() * frame_rows();
      for (int unsigned i = 0; i < n_pix; i++) begin
         case (fill)
            PAT_WHITE:     px = 8'hFF;
            PAT_BLACK:     px = 8'h00;
            PAT_ALTERNATE: px = i[0] ? 8'hFF : 8'h00;
            default: begin
               // mostly uniform, now and then a rail value
               if ($urandom_range(7) == 0)
                  px = {8{1'($urandom)}};
               else
                  px = 8'($urandom);
            end
         endcase
         send_pixel(px, i == n_pix - 1);
      end
      pixels_sent += n_pix;
   endtask

   // Wait until every result is in, then let beats that make no result drain
   task automatic wait_block_idle();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (BLOCK_LATENCY + 6) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- config port
   // Setup then access; upper data bits are junk the block must drop.
   task automatic csr_write(input logic idx, input logic [11:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {20'($urandom), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == bin1331_pkg::REG_WIDTH)
         cfg_width = val;
      else
         cfg_height = val;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Resize only between frames, with the block drained
   task automatic write_frame_size(input logic [11:0] w, input logic [11:0] h);
      wait_block_idle();
      csr_write(bin1331_pkg::REG_WIDTH, w);
      csr_write(bin1331_pkg::REG_HEIGHT, h);
   endtask

   // ---------------------------------------------------------------- tests
   // Smallest frame, odd width with odd height, odd width with even height;
   // rail and alternating fills push the taps to both ends.
   task automatic test_directed_edges();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_frame_size(12'd2, 12'd2);
      send_frame(PAT_WHITE);
      write_frame_size(12'd5, 12'd3);
      send_frame(PAT_ALTERNATE);
      write_frame_size(12'd3, 12'd2);
      send_frame(PAT_BLACK);
   endtask

   // Register values below the legal range saturate to the smallest size.
   task automatic test_size_saturation();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_frame_size(12'd0, 12'd1);
      send_frame(PAT_RANDOM);
      write_frame_size(12'd1, 12'd5);
      send_frame(PAT_RANDOM);
      write_frame_size(12'd3, 12'd0);
      send_frame(PAT_RANDOM);
   endtask

   // Receiver stalls long enough to back the block up into req_tready,
   // then the sender waits for the pipe to empty before the next frame.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_frame_size(12'd12, 12'd6);
      hold_results(300);
      send_frame(PAT_RANDOM);
      wait_block_idle();
      send_frame(PAT_RANDOM);
   endtask

   // Random small frames; about half reuse the size so frames run back to back.
   task automatic test_random_frames(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_items);
      int unsigned start_count;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start_count = pixels_sent;
      while (pixels_sent - start_count < n_items) begin
         if ($urandom_range(1) != 0) begin
            if ($urandom_range(7) == 0)
               write_frame_size(12'($urandom_range(32, 16)), 12'($urandom_range(4, 2)));
            else
               write_frame_size(12'($urandom_range(14, 2)), 12'($urandom_range(9, 2)));
         end
         send_frame(PAT_RANDOM);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_size_saturation();
      test_backpressure();
      test_random_frames(0, 0, 30);     // full rate both sides
      test_random_frames(64, 0, 30);    // sparse input
      test_random_frames(0, 64, 30);    // slow receiver
      test_random_frames(7, 7, 30);     // light jitter both sides

      wait_block_idle();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== binomial_1331_downsample_2x.f =====
rtl/bin1331_pkg.sv
rtl/bin1331_ram.sv
rtl/bin1331_hfilt.sv
rtl/bin1331_vfilt.sv
rtl/binomial_1331_downsample_2x.sv
bench/tb_top.sv
